@@ rtl/core/lcgug_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcgug_pkg
// Shared types and constants of the LCG uniform / Gaussian generator.
// ----------------------------------------------------------------------------
package lcgug_pkg;

   localparam logic [34:0] LCG_MULT      = 35'h5DEECE66D;
   localparam logic [47:0] LCG_INC       = 48'h00000000000B;
   localparam logic [47:0] SEED_SCRAMBLE = 48'h0005DEECE66D;
   localparam logic [31:0] LN2_Q32       = 32'hB17217F8;

   // last value of the shared iteration counter for each iterative unit
   localparam logic [4:0] ITER_SQRT_LAST = 5'd31;
   localparam logic [4:0] ITER_LOG_LAST  = 5'd23;
   localparam logic [4:0] ITER_DIV_LAST  = 5'd30;

   typedef enum logic [1:0] {
      FUNC_RAW     = 2'd0,
      FUNC_UNIFORM = 2'd1,
      FUNC_GAUSS   = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LCG0,
      OP_LCG1,
      OP_LCG2,
      OP_LCG3,
      OP_CAP_HI,
      OP_CAP_LO,
      OP_SET_V,
      OP_SQ1,
      OP_SQ2,
      OP_SUM,
      OP_NORM_INIT,
      OP_NORM,
      OP_SQRT_INIT_S,
      OP_SQRT_STEP,
      OP_RS_SAVE,
      OP_LOG_INIT,
      OP_LOG_MUL,
      OP_LOG_UPD,
      OP_L_CALC,
      OP_Y_MUL,
      OP_SQRT_INIT_Y,
      OP_G_SAVE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_CG_MUL,
      OP_FIN
   } dp_op_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_RAW,
      RES_UNIFORM,
      RES_GAUSS,
      RES_CACHE
   } res_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LCG0,
      ST_LCG1,
      ST_LCG2,
      ST_LCG3,
      ST_CAPTURE,
      ST_SETV,
      ST_SQ1,
      ST_SQ2,
      ST_SUM,
      ST_CHECK,
      ST_NORM_INIT,
      ST_NORM,
      ST_SQRT_S_INIT,
      ST_SQRT_S,
      ST_RS_SAVE,
      ST_LOG_INIT,
      ST_LOG_MUL,
      ST_LOG_UPD,
      ST_L_CALC,
      ST_Y_MUL,
      ST_SQRT_Y_INIT,
      ST_SQRT_Y,
      ST_G_SAVE,
      ST_DIV_INIT,
      ST_DIV,
      ST_CG_MUL,
      ST_FIN,
      ST_OUT
   } ctl_state_type;

   typedef struct packed {
      dp_op_type   op;
      logic        use_v2;
      logic        seed_load;
      logic        req_take;
      logic        res_load;
      res_sel_type res_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic cache_valid;
      logic reject;
      logic norm_done;
      logic sqrt_last;
      logic log_last;
      logic div_last;
   } dp_status_type;

endpackage
`default_nettype wire

@@ rtl/core/lcgug_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcgug_req_if
// Request channel: mode select and raw bit count.
// ----------------------------------------------------------------------------
interface lcgug_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [5:0] bit_count;

   modport source (output valid, func, bit_count, input ready);
   modport sink   (input valid, func, bit_count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lcgug_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcgug_rsp_if
// Result channel: one beat per request.
// ----------------------------------------------------------------------------
interface lcgug_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] raw_value;
   logic        [52:0] uniform_fraction;
   logic signed [31:0] gaussian_value;
   logic               from_cache;

   modport source (output valid, raw_value, uniform_fraction, gaussian_value, from_cache,
                   input ready);
   modport sink   (input valid, raw_value, uniform_fraction, gaussian_value, from_cache,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/core/lcgug_csr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcgug_csr_if
// Seed register write channel.
// ----------------------------------------------------------------------------
interface lcgug_csr_if;
   logic        valid;
   logic        ready;
   logic [47:0] seed_value;

   modport source (output valid, seed_value, input ready);
   modport sink   (input valid, seed_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lcg_uniform_gaussian_generator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_uniform_gaussian_generator_top
// 48-bit LCG random source with raw, uniform and polar Gaussian outputs.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries func (0 raw, 1 uniform, 2 Gaussian, 3 no-op) and
//   bit_count; one rsp_bus beat answers every request, in order.
//   csr_bus writes the seed; write it only while no request is in flight.
//   Requests are taken one at a time, when the sequencer is idle.
//   Every product is formed on the one shared 32x32 multiplier. No-op and
//   cached Gaussian requests go straight to the result load; raw and
//   uniform requests step the LCG first. A fresh Gaussian draws a pair
//   (a rejected pair is drawn again), then normalizes and runs two 32-step
//   square roots, the log iteration and two divide-and-scale passes.
//   The result sits in an output register; a stalled receiver holds it and
//   the next request is accepted meanwhile, finishing once that beat moves.
//   Reset (synchronous) loads the state of a zero seed and clears the cache.
// ----------------------------------------------------------------------------
module lcg_uniform_gaussian_generator_top import lcgug_pkg::*; #(
   parameter int GAUSS_FRAC_BITS = 26
) (
   input wire logic    clock,
   input wire logic    reset,
   lcgug_req_if.sink   req_bus,
   lcgug_rsp_if.source rsp_bus,
   lcgug_csr_if.sink   csr_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;

   lcgug_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcgug_datapath #(
      .GAUSS_FRAC_BITS (GAUSS_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_bit_count    (req_bus.bit_count),
      .csr_seed         (csr_bus.seed_value),
      .raw_value        (rsp_bus.raw_value),
      .uniform_fraction (rsp_bus.uniform_fraction),
      .gaussian_value   (rsp_bus.gaussian_value),
      .from_cache       (rsp_bus.from_cache)
   );

endmodule
`default_nettype wire

@@ rtl/core/lcgug_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcgug_datapath
// Generator state, shared multiplier, sqrt / log / divide iterations and
// result registers. Executes one micro-op per cycle from the controller.
// ----------------------------------------------------------------------------
module lcgug_datapath import lcgug_pkg::*; #(
   parameter int GAUSS_FRAC_BITS = 26
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output      dp_status_type      status,
   input  wire logic [5:0]         req_bit_count,
   input  wire logic [47:0]        csr_seed,
   output      logic signed [31:0] raw_value,
   output      logic [52:0]        uniform_fraction,
   output      logic signed [31:0] gaussian_value,
   output      logic               from_cache
);

   localparam int          RND_SHIFT = 58 - GAUSS_FRAC_BITS;
   localparam logic [63:0] RND_HALF  = 64'd1 << (RND_SHIFT - 1);
   localparam logic [63:0] SQRT_TOP  = 64'd1 << 62;

   logic [47:0] state_ff, state_in;
   logic        cache_valid_ff, cache_valid_in;
   logic [31:0] cached_ff, cached_in;
   logic [5:0]  bit_count_ff, bit_count_in;
   logic [47:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [52:0] uni_ff, uni_in;
   logic [32:0] v1_ff, v1_in, v2_ff, v2_in;
   logic [63:0] s_ff, s_in, sn_ff, sn_in;
   logic [4:0]  j_ff, j_in;
   logic [30:0] m_ff, m_in;
   logic [23:0] f_ff, f_in;
   logic [4:0]  iter_ff, iter_in;
   logic [29:0] l_ff, l_in;
   logic [63:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic [30:0] rs_ff, rs_in;
   logic [31:0] g_ff, g_in;
   logic [32:0] rem_ff, rem_in;
   logic [30:0] q_ff, q_in;
   logic [31:0] gres_ff, gres_in;
   logic [31:0] raw_out_ff, raw_out_in;
   logic [52:0] uni_out_ff, uni_out_in;
   logic [31:0] gauss_out_ff, gauss_out_in;
   logic        from_cache_ff, from_cache_in;

   logic [31:0] mul_a, mul_b;
   logic        mul_en;
   logic [32:0] v1_neg, v2_neg;
   logic [31:0] v1_abs, v2_abs, v_sel_abs;
   logic [5:0]  nb_eff, raw_sh;
   logic [47:0] raw_shifted;
   logic [31:0] raw_calc;
   logic [32:0] v_new;
   logic [63:0] sq_t;
   logic [31:0] m2;
   logic [5:0]  e_val;
   logic [63:0] div_x;
   logic        div_ge;
   logic [32:0] div_diff, div_keep;
   logic [63:0] rounded, mag;
   logic        v_neg;
   logic [31:0] g_val;

   // multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (cmd.op)
         OP_LCG0: begin
            mul_a = {8'd0, state_ff[23:0]};
            mul_b = {8'd0, LCG_MULT[23:0]};
         end
         OP_LCG1: begin
            mul_a = {8'd0, state_ff[23:0]};
            mul_b = {21'd0, LCG_MULT[34:24]};
         end
         OP_LCG2: begin
            mul_a = {8'd0, state_ff[47:24]};
            mul_b = {8'd0, LCG_MULT[23:0]};
         end
         OP_SQ1: begin
            mul_a = v1_abs;
            mul_b = v1_abs;
         end
         OP_SQ2: begin
            mul_a = v2_abs;
            mul_b = v2_abs;
         end
         OP_LOG_MUL: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
         end
         OP_Y_MUL: begin
            mul_a = {2'd0, l_ff};
            mul_b = LN2_Q32;
         end
         OP_CG_MUL: begin
            mul_a = {1'b0, q_ff};
            mul_b = g_ff;
         end
         default: mul_en = 1'b0;
      endcase
   end

   always_comb begin
      v1_neg      = 33'd0 - v1_ff;
      v2_neg      = 33'd0 - v2_ff;
      v1_abs      = v1_ff[32] ? v1_neg[31:0] : v1_ff[31:0];
      v2_abs      = v2_ff[32] ? v2_neg[31:0] : v2_ff[31:0];
      v_sel_abs   = cmd.use_v2 ? v2_abs : v1_abs;
      v_neg       = cmd.use_v2 ? v2_ff[32] : v1_ff[32];

      nb_eff      = (bit_count_ff > 6'd48) ? 6'd48 : bit_count_ff;
      raw_sh      = 6'd48 - nb_eff;
      raw_shifted = state_ff >> raw_sh;
      raw_calc    = (bit_count_ff == 6'd0) ? 32'd0 : raw_shifted[31:0];

      // v = 2w - 2^31 with w the top 31 bits of the 53-bit draw
      v_new       = {1'b0, uni_ff[52:22], 1'b0} - 33'h080000000;
      sq_t        = r_ff + bit_ff;
      m2          = prod_ff[61:30];
      e_val       = sn_ff[61] ? ({j_ff, 1'b0} + 6'd1) : ({j_ff, 1'b0} + 6'd2);
      div_x       = {32'd0, v_sel_abs} << j_ff;
      div_ge      = rem_ff >= {2'd0, rs_ff};
      div_diff    = rem_ff - {2'd0, rs_ff};
      div_keep    = div_ge ? div_diff : rem_ff;

      rounded     = prod_ff + RND_HALF;
      mag         = rounded >> RND_SHIFT;
      if (v_neg) begin
         g_val = (mag > 64'h80000000) ? 32'h80000000 : (32'd0 - mag[31:0]);
      end else begin
         g_val = (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      cache_valid_in = cache_valid_ff;
      cached_in      = cached_ff;
      bit_count_in   = bit_count_ff;
      acc_in         = acc_ff;
      prod_in        = mul_en ? (mul_a * mul_b) : prod_ff;
      uni_in         = uni_ff;
      v1_in          = v1_ff;
      v2_in          = v2_ff;
      s_in           = s_ff;
      sn_in          = sn_ff;
      j_in           = j_ff;
      m_in           = m_ff;
      f_in           = f_ff;
      iter_in        = iter_ff;
      l_in           = l_ff;
      x_in           = x_ff;
      r_in           = r_ff;
      bit_in         = bit_ff;
      rs_in          = rs_ff;
      g_in           = g_ff;
      rem_in         = rem_ff;
      q_in           = q_ff;
      gres_in        = gres_ff;
      raw_out_in     = raw_out_ff;
      uni_out_in     = uni_out_ff;
      gauss_out_in   = gauss_out_ff;
      from_cache_in  = from_cache_ff;

      if (cmd.req_take) begin
         bit_count_in = req_bit_count;
      end

      unique case (cmd.op)
         OP_LCG1: acc_in = prod_ff[47:0];
         OP_LCG2: acc_in[47:24] = acc_ff[47:24] + prod_ff[23:0];
         OP_LCG3: state_in = acc_ff + {prod_ff[23:0], 24'd0} + LCG_INC;
         OP_CAP_HI: uni_in = {state_ff[47:22], 27'd0};
         OP_CAP_LO: uni_in = {uni_ff[52:27], state_ff[47:21]};
         OP_SET_V: begin
            if (cmd.use_v2) begin
               v2_in = v_new;
            end else begin
               v1_in = v_new;
            end
         end
         OP_SQ2: s_in = prod_ff;
         OP_SUM: s_in = s_ff + prod_ff;
         OP_NORM_INIT: begin
            sn_in = s_ff;
            j_in  = 5'd0;
         end
         OP_NORM: begin
            if (sn_ff[63:60] == 4'd0) begin
               sn_in = {sn_ff[61:0], 2'b00};
               j_in  = j_ff + 5'd1;
            end
         end
         OP_SQRT_INIT_S: begin
            x_in    = sn_ff;
            r_in    = '0;
            bit_in  = SQRT_TOP;
            iter_in = 5'd0;
         end
         OP_SQRT_INIT_Y: begin
            x_in    = {prod_ff[62:0], 1'b0};
            r_in    = '0;
            bit_in  = SQRT_TOP;
            iter_in = 5'd0;
         end
         OP_SQRT_STEP: begin
            if (x_ff >= sq_t) begin
               x_in = x_ff - sq_t;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff + 5'd1;
         end
         OP_RS_SAVE: rs_in = r_ff[30:0];
         OP_LOG_INIT: begin
            m_in    = sn_ff[61] ? sn_ff[61:31] : sn_ff[60:30];
            f_in    = '0;
            iter_in = 5'd0;
         end
         OP_LOG_UPD: begin
            m_in    = m2[31] ? m2[31:1] : m2[30:0];
            f_in    = {f_ff[22:0], m2[31]};
            iter_in = iter_ff + 5'd1;
         end
         OP_L_CALC: l_in = {e_val, 24'd0} - {6'd0, f_ff};
         OP_G_SAVE: g_in = r_ff[31:0];
         OP_DIV_INIT: begin
            rem_in  = div_x[32:0];
            q_in    = '0;
            iter_in = 5'd0;
         end
         OP_DIV_STEP: begin
            rem_in  = {div_keep[31:0], 1'b0};
            q_in    = {q_ff[29:0], div_ge};
            iter_in = iter_ff + 5'd1;
         end
         OP_FIN: begin
            if (cmd.use_v2) begin
               cached_in      = g_val;
               cache_valid_in = 1'b1;
            end else begin
               gres_in = g_val;
            end
         end
         default: begin
         end
      endcase

      if (cmd.res_load) begin
         raw_out_in    = '0;
         uni_out_in    = '0;
         gauss_out_in  = '0;
         from_cache_in = 1'b0;
         unique case (cmd.res_sel)
            RES_RAW:     raw_out_in = raw_calc;
            RES_UNIFORM: uni_out_in = uni_ff;
            RES_GAUSS:   gauss_out_in = gres_ff;
            RES_CACHE: begin
               gauss_out_in   = cached_ff;
               from_cache_in  = 1'b1;
               cache_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.seed_load) begin
         state_in       = csr_seed ^ SEED_SCRAMBLE;
         cache_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEED_SCRAMBLE;
         cache_valid_ff <= 1'b0;
         cached_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         cache_valid_ff <= cache_valid_in;
         cached_ff      <= cached_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_count_ff  <= bit_count_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      uni_ff        <= uni_in;
      v1_ff         <= v1_in;
      v2_ff         <= v2_in;
      s_ff          <= s_in;
      sn_ff         <= sn_in;
      j_ff          <= j_in;
      m_ff          <= m_in;
      f_ff          <= f_in;
      iter_ff       <= iter_in;
      l_ff          <= l_in;
      x_ff          <= x_in;
      r_ff          <= r_in;
      bit_ff        <= bit_in;
      rs_ff         <= rs_in;
      g_ff          <= g_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      gres_ff       <= gres_in;
      raw_out_ff    <= raw_out_in;
      uni_out_ff    <= uni_out_in;
      gauss_out_ff  <= gauss_out_in;
      from_cache_ff <= from_cache_in;
   end

   assign status.cache_valid = cache_valid_ff;
   assign status.reject      = (s_ff == 64'd0) || (s_ff[63:62] != 2'd0);
   assign status.norm_done   = (sn_ff[63:60] != 4'd0);
   assign status.sqrt_last   = (iter_ff == ITER_SQRT_LAST);
   assign status.log_last    = (iter_ff == ITER_LOG_LAST);
   assign status.div_last    = (iter_ff == ITER_DIV_LAST);

   assign raw_value        = raw_out_ff;
   assign uniform_fraction = uni_out_ff;
   assign gaussian_value   = gauss_out_ff;
   assign from_cache       = from_cache_ff;

`ifndef SYNTHESIS
   // the cached value only becomes valid from the second half of a pair
   a_cache_set: assert property (@(posedge clock) disable iff (reset)
      $rose(cache_valid_ff) |-> $past(cmd.op == OP_FIN && cmd.use_v2))
      else $error("cache_valid set outside of second-value finish");
   // divider remainder stays below 2^32 while stepping
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV_STEP) |-> !rem_ff[32])
      else $error("divider remainder overflow");
   a_cache_take: assert property (@(posedge clock) disable iff (reset)
      (cmd.res_load && cmd.res_sel == RES_CACHE) |=> !cache_valid_ff)
      else $error("cached value not consumed");
`endif

endmodule
`default_nettype wire

@@ rtl/core/lcgug_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcgug_ctrl
// Sequencer: walks each request through its draws (Gaussian: rejection test,
// sqrt, log, divide) and result load, issuing one datapath micro-op per cycle.
// ----------------------------------------------------------------------------
module lcgug_ctrl import lcgug_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [1:0]    req_func,
   output      logic          req_ready,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire dp_status_type status,
   output      dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   func_type      func_ff, func_in;
   logic [1:0]    draw_ff, draw_in;
   logic          cached_ff, cached_in;
   logic          second_ff, second_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_fire, out_free;
   func_type      req_func_t;

   assign req_func_t = func_type'(req_func);
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_func_t == FUNC_NONE ||
                   (req_func_t == FUNC_GAUSS && status.cache_valid)) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_LCG0;
               end
            end
         end
         ST_LCG0: state_in = ST_LCG1;
         ST_LCG1: state_in = ST_LCG2;
         ST_LCG2: state_in = ST_LCG3;
         ST_LCG3: state_in = ST_CAPTURE;
         ST_CAPTURE: begin
            unique case (func_ff)
               FUNC_UNIFORM: state_in = draw_ff[0] ? ST_OUT : ST_LCG0;
               FUNC_GAUSS:   state_in = draw_ff[0] ? ST_SETV : ST_LCG0;
               default:      state_in = ST_OUT;
            endcase
         end
         ST_SETV:        state_in = (draw_ff == 2'd0) ? ST_SQ1 : ST_LCG0;
         ST_SQ1:         state_in = ST_SQ2;
         ST_SQ2:         state_in = ST_SUM;
         ST_SUM:         state_in = ST_CHECK;
         ST_CHECK:       state_in = status.reject ? ST_LCG0 : ST_NORM_INIT;
         ST_NORM_INIT:   state_in = ST_NORM;
         ST_NORM:        state_in = status.norm_done ? ST_SQRT_S_INIT : ST_NORM;
         ST_SQRT_S_INIT: state_in = ST_SQRT_S;
         ST_SQRT_S:      state_in = status.sqrt_last ? ST_RS_SAVE : ST_SQRT_S;
         ST_RS_SAVE:     state_in = ST_LOG_INIT;
         ST_LOG_INIT:    state_in = ST_LOG_MUL;
         ST_LOG_MUL:     state_in = ST_LOG_UPD;
         ST_LOG_UPD:     state_in = status.log_last ? ST_L_CALC : ST_LOG_MUL;
         ST_L_CALC:      state_in = ST_Y_MUL;
         ST_Y_MUL:       state_in = ST_SQRT_Y_INIT;
         ST_SQRT_Y_INIT: state_in = ST_SQRT_Y;
         ST_SQRT_Y:      state_in = status.sqrt_last ? ST_G_SAVE : ST_SQRT_Y;
         ST_G_SAVE:      state_in = ST_DIV_INIT;
         ST_DIV_INIT:    state_in = ST_DIV;
         ST_DIV:         state_in = status.div_last ? ST_CG_MUL : ST_DIV;
         ST_CG_MUL:      state_in = ST_FIN;
         ST_FIN:         state_in = second_ff ? ST_OUT : ST_DIV_INIT;
         ST_OUT:         state_in = out_free ? ST_IDLE : ST_OUT;
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd           = '0;
      cmd.op        = OP_NONE;
      cmd.res_sel   = RES_ZERO;
      cmd.seed_load = csr_valid;
      cmd.req_take  = req_fire;
      cmd.use_v2    = second_ff;
      unique case (state_ff)
         ST_LCG0: cmd.op = OP_LCG0;
         ST_LCG1: cmd.op = OP_LCG1;
         ST_LCG2: cmd.op = OP_LCG2;
         ST_LCG3: cmd.op = OP_LCG3;
         ST_CAPTURE: begin
            if (func_ff != FUNC_RAW) begin
               cmd.op = draw_ff[0] ? OP_CAP_LO : OP_CAP_HI;
            end
         end
         ST_SETV: begin
            cmd.op     = OP_SET_V;
            cmd.use_v2 = (draw_ff == 2'd0);
         end
         ST_SQ1:         cmd.op = OP_SQ1;
         ST_SQ2:         cmd.op = OP_SQ2;
         ST_SUM:         cmd.op = OP_SUM;
         ST_NORM_INIT:   cmd.op = OP_NORM_INIT;
         ST_NORM:        cmd.op = OP_NORM;
         ST_SQRT_S_INIT: cmd.op = OP_SQRT_INIT_S;
         ST_SQRT_S:      cmd.op = OP_SQRT_STEP;
         ST_RS_SAVE:     cmd.op = OP_RS_SAVE;
         ST_LOG_INIT:    cmd.op = OP_LOG_INIT;
         ST_LOG_MUL:     cmd.op = OP_LOG_MUL;
         ST_LOG_UPD:     cmd.op = OP_LOG_UPD;
         ST_L_CALC:      cmd.op = OP_L_CALC;
         ST_Y_MUL:       cmd.op = OP_Y_MUL;
         ST_SQRT_Y_INIT: cmd.op = OP_SQRT_INIT_Y;
         ST_SQRT_Y:      cmd.op = OP_SQRT_STEP;
         ST_G_SAVE:      cmd.op = OP_G_SAVE;
         ST_DIV_INIT:    cmd.op = OP_DIV_INIT;
         ST_DIV:         cmd.op = OP_DIV_STEP;
         ST_CG_MUL:      cmd.op = OP_CG_MUL;
         ST_FIN:         cmd.op = OP_FIN;
         ST_OUT: begin
            cmd.res_load = out_free;
            if (cached_ff) begin
               cmd.res_sel = RES_CACHE;
            end else begin
               unique case (func_ff)
                  FUNC_RAW:     cmd.res_sel = RES_RAW;
                  FUNC_UNIFORM: cmd.res_sel = RES_UNIFORM;
                  FUNC_GAUSS:   cmd.res_sel = RES_GAUSS;
                  default:      cmd.res_sel = RES_ZERO;
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      func_in      = func_ff;
      draw_in      = draw_ff;
      cached_in    = cached_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         func_in   = req_func_t;
         draw_in   = 2'd0;
         cached_in = (req_func_t == FUNC_GAUSS) && status.cache_valid;
      end
      // draw index wraps to zero after the fourth draw of a pair
      if (state_ff == ST_CAPTURE) begin
         draw_in = draw_ff + 2'd1;
      end
      if (state_ff == ST_G_SAVE) begin
         second_in = 1'b0;
      end else if (state_ff == ST_FIN) begin
         second_in = 1'b1;
      end
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         func_ff      <= FUNC_RAW;
         draw_ff      <= 2'd0;
         cached_ff    <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         func_ff      <= func_in;
         draw_ff      <= draw_in;
         cached_ff    <= cached_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while pending");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("accepted request produced no work");
   a_cache_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LCG0) |-> !cached_ff)
      else $error("cached request is drawing");
`endif

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the LCG generator: raw top bits, 53-bit uniform fractions and polar
// Gaussian pairs against an in-bench predictor, with random idling on both
// channels and seed writes between phases.
// ----------------------------------------------------------------------------
module tb import lcgug_pkg::*; ();

   localparam int GFRAC = 26;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [31:0] raw_value;
      logic        [52:0] uniform_fraction;
      logic signed [31:0] gaussian_value;
      logic               from_cache;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcgug_req_if req_bus ();
   lcgug_rsp_if rsp_bus ();
   lcgug_csr_if csr_bus ();

   lcg_uniform_gaussian_generator_top #(.GAUSS_FRAC_BITS(GFRAC)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [47:0] gen_state;
   logic        pair_pending;
   logic [31:0] pair_second;

   rsp_beat_type expected_q[$];
   int        mismatches;
   int        beats_checked;
   int        gauss_fresh, gauss_cached;
   int        idle_pct;
   int        idle_cycles;
   bit        timed_out;

   function automatic logic [47:0] step_state(input logic [47:0] st);
      logic [95:0] prod;
      prod = st * 96'h5DEECE66D + 96'hB;
      return prod[47:0];
   endfunction

   function automatic logic [63:0] next_bits(input int nb);
      gen_state = step_state(gen_state);
      if (nb == 0) return 64'd0;
      if (nb > 48) nb = 48;
      return {16'd0, gen_state} >> (48 - nb);
   endfunction

   function automatic logic [63:0] next_fraction();
      logic [63:0] hi, lo;
      hi = next_bits(26);
      lo = next_bits(27);
      return (hi << 27) + lo;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] scale_polar(input longint v, input logic [63:0] s,
                                               input logic [63:0] g);
      logic [63:0] av, sn, c, prod, mag;
      int j, sh;
      av = (v < 0) ? -v : v;
      sn = s;
      j = 0;
      sh = 58 - GFRAC;
      while (sn < (64'd1 << 60)) begin
         sn = sn << 2;
         j++;
      end
      c = ((av << j) << 30) / int_sqrt(sn);
      prod = c * g;
      mag = (prod + (64'd1 << (sh - 1))) >> sh;
      if (v < 0) begin
         if (mag > 64'h80000000) mag = 64'h80000000;
         return 32'd0 - mag[31:0];
      end
      if (mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
      return mag[31:0];
   endfunction

   function automatic logic [31:0] fresh_gaussian();
      longint v1, v2;
      logic [63:0] s, m, f, lg, g;
      int p, e;
      forever begin
         v1 = longint'((next_fraction() >> 22) * 2) - (64'sd1 <<< 31);
         v2 = longint'((next_fraction() >> 22) * 2) - (64'sd1 <<< 31);
         s = v1 * v1 + v2 * v2;
         if (s != 0 && s < (64'd1 << 62)) break;
      end
      p = 0;
      while ((s >> (p + 1)) != 0) p++;
      e = 62 - p;
      m = (p >= 30) ? (s >> (p - 30)) : (s << (30 - p));
      f = 0;
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         f = f << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            f = f | 1;
         end
      end
      lg = (64'(e) << 24) - f;
      g = int_sqrt(2 * (lg * 64'hB17217F8));
      pair_second = scale_polar(v2, s, g);
      pair_pending = 1'b1;
      return scale_polar(v1, s, g);
   endfunction

   function automatic rsp_beat_type predict_beat(input func_type fn, input logic [5:0] nb);
      rsp_beat_type r;
      logic [63:0] t;
      r = '{32'sd0, 53'd0, 32'sd0, 1'b0};
      case (fn)
         FUNC_RAW: begin
            t = next_bits(nb);
            r.raw_value = t[31:0];
         end
         FUNC_UNIFORM: begin
            t = next_fraction();
            r.uniform_fraction = t[52:0];
         end
         FUNC_GAUSS: begin
            if (pair_pending) begin
               pair_pending = 1'b0;
               r.gaussian_value = pair_second;
               r.from_cache = 1'b1;
               gauss_cached++;
            end else begin
               r.gaussian_value = fresh_gaussian();
               gauss_fresh++;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic bit roll_idle();
      return ($urandom_range(99) < idle_pct);
   endfunction

   // valid stays up after the last beat until the next item or an idle cycle
   task automatic send_req(input func_type fn, input logic [5:0] nb);
      while (roll_idle()) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= fn;
      req_bus.bit_count <= nb;
      expected_q.push_back(predict_beat(fn, nb));
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_seed(input logic [47:0] seed);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.seed_value <= seed;
      do @(posedge clock); while (!csr_bus.ready);
      gen_state = seed ^ SEED_SCRAMBLE;
      pair_pending = 1'b0;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // receiver: random stalls, compare each beat with the oldest prediction
   always @(negedge clock) begin
      if (!reset) rsp_bus.ready <= !roll_idle();
   end

   always @(posedge clock) begin
      rsp_beat_type exp_b;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat");
         end else begin
            exp_b = expected_q.pop_front();
            if (rsp_bus.raw_value !== exp_b.raw_value ||
                rsp_bus.uniform_fraction !== exp_b.uniform_fraction ||
                rsp_bus.gaussian_value !== exp_b.gaussian_value ||
                rsp_bus.from_cache !== exp_b.from_cache) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp raw %h uni %h gau %h c %b / got raw %h uni %h gau %h c %b",
                           exp_b.raw_value, exp_b.uniform_fraction, exp_b.gaussian_value,
                           exp_b.from_cache, rsp_bus.raw_value, rsp_bus.uniform_fraction,
                           rsp_bus.gaussian_value, rsp_bus.from_cache);
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_raw_directed();
      send_req(FUNC_RAW, 6'd0);
      send_req(FUNC_RAW, 6'd1);
      send_req(FUNC_RAW, 6'd31);
      send_req(FUNC_RAW, 6'd32);
      send_req(FUNC_RAW, 6'd33);
      send_req(FUNC_RAW, 6'd48);
      send_req(FUNC_RAW, 6'd49);
      send_req(FUNC_RAW, 6'd63);
   endtask

   task automatic test_modes_directed();
      send_req(FUNC_UNIFORM, 6'd63);
      send_req(FUNC_NONE, 6'd42);
      send_req(FUNC_GAUSS, 6'd0);
      send_req(FUNC_GAUSS, 6'd21);
      send_req(FUNC_GAUSS, 6'd0);
      send_req(FUNC_UNIFORM, 6'd0);
   endtask

   task automatic test_seed_discards_cache();
      send_req(FUNC_GAUSS, 6'd0);
      write_seed(48'hFFFF_FFFF_FFFF);
      send_req(FUNC_GAUSS, 6'd0);
      send_req(FUNC_GAUSS, 6'd0);
      write_seed(48'h0);
      send_req(FUNC_GAUSS, 6'd0);
   endtask

   task automatic test_random(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 35) send_req(FUNC_RAW, 6'($urandom_range(63)));
         else if (r < 60) send_req(FUNC_UNIFORM, 6'($urandom));
         else if (r < 92) send_req(FUNC_GAUSS, 6'($urandom));
         else send_req(FUNC_NONE, 6'($urandom));
      end
   endtask

   initial begin
      mismatches = 0;
      beats_checked = 0;
      gauss_fresh = 0;
      gauss_cached = 0;
      idle_cycles = 0;
      idle_pct = 20;
      gen_state = SEED_SCRAMBLE;
      pair_pending = 1'b0;
      pair_second = 32'd0;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_NONE;
      req_bus.bit_count = 6'd0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.seed_value = 48'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_raw_directed();
      test_modes_directed();
      test_seed_discards_cache();
      write_seed(48'h1234_5678_9ABC);
      test_random(150);
      idle_pct = 0;
      write_seed(48'({$urandom, $urandom}));
      test_random(100);
      idle_pct = 20;
      write_seed(48'({$urandom, $urandom}));
      test_random(150);
      drain();

      $display("checked %0d result beats: raw, uniform, no-op, %0d fresh and %0d cached Gaussians",
               beats_checked, gauss_fresh, gauss_cached);
      $display("seeds written: zero, all ones and random; %0d mismatches", mismatches);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/lcgug_pkg.sv
rtl/core/lcgug_req_if.sv
rtl/core/lcgug_rsp_if.sv
rtl/core/lcgug_csr_if.sv
rtl/core/lcgug_datapath.sv
rtl/core/lcgug_ctrl.sv
rtl/core/lcg_uniform_gaussian_generator_top.sv
test/tb.sv
